/* rtl/core/alpd_pkg.sv */
package alpd_pkg;

   localparam int MAX_AXES  = 2;
   localparam int AXIS_W    = 1;
   localparam int FRAC_BITS = 16;
   localparam int COEF_BITS = 16;
   localparam int SHIFT_ONE = FRAC_BITS - 6;
   localparam int SHIFT_TWO = FRAC_BITS - 5;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int DZ_W       = 24;

   localparam logic signed [15:0] COEF_FB  = 16'sd24217;
   localparam logic signed [15:0] COEF_FB2 = -16'sd12833;
   localparam logic signed [15:0] COEF_FF  = 16'sd13538;

   localparam logic [1:0]      AXIS_COUNT_ONE     = 2'd1;
   localparam logic [1:0]      AXIS_COUNT_RESET   = 2'd2;
   localparam logic [DZ_W-1:0] HOLD_THRESH_RESET  = 24'd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_AXIS_COUNT,
      REG_FILTER_ENABLE,
      REG_DEADZONE_ENABLE,
      REG_HOLD_THRESH
   } csr_reg_type;

   typedef struct packed {
      logic [AXIS_W-1:0]  axis;
      logic signed [15:0] raw_sample;
   } req_type;

   typedef struct packed {
      logic [AXIS_W-1:0]  axis_out;
      logic signed [31:0] angle;
   } rsp_type;

   typedef struct packed {
      logic [1:0]      axis_count;
      logic            filter_enable;
      logic            deadzone_enable;
      logic [DZ_W-1:0] hold_thresh;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] x1;
      logic signed [31:0] x2;
      logic signed [31:0] y1;
      logic signed [31:0] y2;
      logic signed [31:0] held;
   } hist_type;

   typedef struct packed {
      logic              re;
      logic [AXIS_W-1:0] raddr;
      logic              we;
      logic [AXIS_W-1:0] waddr;
      hist_type          wdata;
   } mem_req_type;

endpackage

/* rtl/core/alpd_csr.sv */
module alpd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [alpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [alpd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output alpd_pkg::cfg_type                 cfg
);

   alpd_pkg::cfg_type cfg_ff;
   alpd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (alpd_pkg::csr_reg_type'(csr_index))
            alpd_pkg::REG_AXIS_COUNT:      cfg_in.axis_count      = csr_wdata[1:0];
            alpd_pkg::REG_FILTER_ENABLE:   cfg_in.filter_enable   = csr_wdata[0];
            alpd_pkg::REG_DEADZONE_ENABLE: cfg_in.deadzone_enable = csr_wdata[0];
            alpd_pkg::REG_HOLD_THRESH:     cfg_in.hold_thresh = csr_wdata[alpd_pkg::DZ_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_count      <= alpd_pkg::AXIS_COUNT_RESET;
         cfg_ff.filter_enable   <= 1'b1;
         cfg_ff.deadzone_enable <= 1'b1;
         cfg_ff.hold_thresh     <= alpd_pkg::HOLD_THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/alpd_state_mem.sv */
module alpd_state_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  alpd_pkg::mem_req_type mem_req,
   output alpd_pkg::hist_type    rd_data
);

   alpd_pkg::hist_type                 mem_ff [alpd_pkg::MAX_AXES];
   logic [alpd_pkg::MAX_AXES-1:0]      vld_ff;
   alpd_pkg::hist_type                 rd_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_req.we) begin
         vld_ff[mem_req.waddr] <= 1'b1;
      end
   end

   // A write to the entry being read in the same cycle is bypassed to the read data.
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         if (mem_req.we && (mem_req.waddr == mem_req.raddr)) begin
            rd_ff <= mem_req.wdata;
         end else if (!vld_ff[mem_req.raddr]) begin
            rd_ff <= '0;
         end else begin
            rd_ff <= mem_ff[mem_req.raddr];
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

/* rtl/core/alpd_pipe.sv */
module alpd_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  alpd_pkg::cfg_type     cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  alpd_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output alpd_pkg::rsp_type     rsp_data,
   output alpd_pkg::mem_req_type mem_req,
   input  alpd_pkg::hist_type    rd_data
);

   typedef struct packed {
      logic [alpd_pkg::AXIS_W-1:0] ax;
      logic signed [31:0]          x;
   } s1_type;

   typedef struct packed {
      logic [alpd_pkg::AXIS_W-1:0] ax;
      logic signed [31:0]          x;
      alpd_pkg::hist_type          hist;
      logic signed [33:0]          sum;
      logic signed [47:0]          p1;
      logic signed [47:0]          p2;
   } s2_type;

   typedef struct packed {
      logic [alpd_pkg::AXIS_W-1:0] ax;
      logic signed [31:0]          x;
      alpd_pkg::hist_type          hist;
      logic signed [49:0]          p3;
      logic signed [32:0]          f12;
   } s3_type;

   typedef struct packed {
      logic [alpd_pkg::AXIS_W-1:0] ax;
      logic signed [31:0]          x;
      alpd_pkg::hist_type          hist;
      logic signed [31:0]          ys;
   } s4_type;

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, rsp_v_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   alpd_pkg::rsp_type rsp_ff, rsp_in;

   logic out_free, s4_mv, s4_free, s3_free, s2_free, s1_free;
   logic one_axis, hazard, accept;
   logic [alpd_pkg::AXIS_W-1:0] ax_in;
   logic signed [31:0] raw_ext, x_in;
   logic signed [34:0] y_full;
   logic signed [31:0] v, dz_out;
   logic signed [32:0] diff;
   logic [32:0] mag;
   logic upd;
   alpd_pkg::hist_type hist_new;

   assign out_free = !rsp_v_ff || !rsp_stall;
   assign s4_mv    = s4_v_ff && out_free;
   assign s4_free  = !s4_v_ff || out_free;
   assign s3_free  = !s3_v_ff || s4_free;
   assign s2_free  = !s2_v_ff || s3_free;
   assign s1_free  = !s1_v_ff || s2_free;

   assign one_axis = (cfg.axis_count == alpd_pkg::AXIS_COUNT_ONE);
   assign ax_in    = (one_axis || (alpd_pkg::MAX_AXES < 2)) ? '0 : req_data.axis;
   assign raw_ext  = 32'(req_data.raw_sample);
   assign x_in     = one_axis ? (raw_ext <<< alpd_pkg::SHIFT_ONE)
                              : (raw_ext <<< alpd_pkg::SHIFT_TWO);

   // An axis still in flight blocks a new beat for that axis until its write-back edge.
   assign hazard = (s1_v_ff && (s1_ff.ax == ax_in)) ||
                   (s2_v_ff && (s2_ff.ax == ax_in)) ||
                   (s3_v_ff && (s3_ff.ax == ax_in)) ||
                   (s4_v_ff && (s4_ff.ax == ax_in) && !s4_mv);

   assign req_stall = !s1_free || hazard;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_in.ax = ax_in;
      s1_in.x  = x_in;

      s2_in.ax   = s1_ff.ax;
      s2_in.x    = s1_ff.x;
      s2_in.hist = rd_data;
      s2_in.sum  = 34'(s1_ff.x) + (34'(rd_data.x1) <<< 1) + 34'(rd_data.x2);
      s2_in.p1   = alpd_pkg::COEF_FB * rd_data.y1;
      s2_in.p2   = alpd_pkg::COEF_FB2 * rd_data.y2;

      s3_in.ax   = s2_ff.ax;
      s3_in.x    = s2_ff.x;
      s3_in.hist = s2_ff.hist;
      s3_in.p3   = alpd_pkg::COEF_FF * s2_ff.sum;
      s3_in.f12  = 33'($signed(s2_ff.p1[47:alpd_pkg::COEF_BITS])) +
                   33'($signed(s2_ff.p2[47:alpd_pkg::COEF_BITS]));

      y_full     = 35'(s3_ff.f12) + 35'($signed(s3_ff.p3[49:alpd_pkg::COEF_BITS]));
      s4_in.ax   = s3_ff.ax;
      s4_in.x    = s3_ff.x;
      s4_in.hist = s3_ff.hist;
      if (y_full[34:31] == 4'b0000 || y_full[34:31] == 4'b1111) begin
         s4_in.ys = y_full[31:0];
      end else if (y_full[34]) begin
         s4_in.ys = {1'b1, 31'd0};
      end else begin
         s4_in.ys = {1'b0, {31{1'b1}}};
      end
   end

   always_comb begin
      v      = cfg.filter_enable ? s4_ff.ys : s4_ff.x;
      diff   = 33'(v) - 33'(s4_ff.hist.held);
      mag    = diff[32] ? 33'(-diff) : 33'(diff);
      upd    = mag > 33'(cfg.hold_thresh);
      dz_out = (cfg.deadzone_enable && !upd) ? s4_ff.hist.held : v;

      hist_new = s4_ff.hist;
      if (cfg.filter_enable) begin
         hist_new.x2 = s4_ff.hist.x1;
         hist_new.x1 = s4_ff.x;
         hist_new.y2 = s4_ff.hist.y1;
         hist_new.y1 = s4_ff.ys;
      end
      if (cfg.deadzone_enable && upd) begin
         hist_new.held = v;
      end

      rsp_in.axis_out = s4_ff.ax;
      rsp_in.angle    = dz_out;

      mem_req.re    = accept;
      mem_req.raddr = ax_in;
      mem_req.we    = s4_mv;
      mem_req.waddr = s4_ff.ax;
      mem_req.wdata = hist_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_v_ff <= accept;
         end
         if (s2_free) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_free) begin
            s3_v_ff <= s2_v_ff;
         end
         if (s4_free) begin
            s4_v_ff <= s3_v_ff;
         end
         if (out_free) begin
            rsp_v_ff <= s4_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_v_ff && s2_free) begin
         s2_ff <= s2_in;
      end
      if (s2_v_ff && s3_free) begin
         s3_ff <= s3_in;
      end
      if (s3_v_ff && s4_free) begin
         s4_ff <= s4_in;
      end
      if (s4_mv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_s1_s2_axes: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s2_v_ff |-> s1_ff.ax != s2_ff.ax)
      else $error("two beats of one axis in the first two stages");

   a_s1_s3_axes: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s3_v_ff |-> s1_ff.ax != s3_ff.ax)
      else $error("two beats of one axis in stages one and three");

   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_v_ff && (s1_ff.ax == $past(ax_in)))
      else $error("accepted beat did not enter the first stage");

   a_one_axis_zero: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && (cfg.axis_count == alpd_pkg::AXIS_COUNT_ONE) |-> s1_ff.ax == '0)
      else $error("one-axis mode used a history entry other than zero");
`endif

endmodule

/* rtl/core/angle_lowpass_deadzone_unit.sv */
// Channel   Ports                                   Direction  Moves
// request   req_valid, req_stall, req_data          in         one sample beat
// response  rsp_valid, rsp_stall, rsp_data          out        one angle beat
// config    csr_we, csr_index, csr_wdata            in         one register write
//
// An accepted beat passes the s1 to s4 stage registers, then the output register.
// Beats for different axes enter on consecutive cycles unless the pipe stalls; a beat
// for an axis still in flight waits for its history write-back.
// Reset is synchronous: it loads config defaults and clears stage and history valids.
// A stalled response holds the output register; the stages behind it fill before
// req_stall rises for lack of room, though an axis hazard can raise it sooner.
module angle_lowpass_deadzone_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  alpd_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output alpd_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [alpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [alpd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   alpd_pkg::cfg_type     cfg;
   alpd_pkg::mem_req_type mem_req;
   alpd_pkg::hist_type    rd_data;

   alpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   alpd_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   alpd_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

endmodule

/* verif/tb_top.sv */
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ANGLE_MAX = 64'sd2147483647;
   localparam longint ANGLE_MIN = -64'sd2147483648;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   alpd_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   alpd_pkg::rsp_type               rsp_data;
   logic                            csr_we = 1'b0;
   logic [alpd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [alpd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   alpd_pkg::req_type  pending_samples [$];
   alpd_pkg::rsp_type  expected_angles [$];
   alpd_pkg::cfg_type  cfg_shadow;
   alpd_pkg::hist_type axis_hist [alpd_pkg::MAX_AXES];

   int  samples_queued = 0;
   int  samples_accepted = 0;
   int  mismatch_count = 0;
   int  req_idle_max = 0;
   int  rsp_idle_max = 0;
   int  req_gap = 0;
   int  rsp_wait = 0;
   int  long_hold = 0;
   int  walk [alpd_pkg::MAX_AXES];
   bit  req_beat_taken = 1'b0;
   bit  rsp_beat_taken = 1'b0;

   angle_lowpass_deadzone_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scales, filters and deadzones one sample beat, updating the per-axis history.
   function automatic alpd_pkg::rsp_type predict_angle(alpd_pkg::req_type sample);
      alpd_pkg::rsp_type result;
      int      ax;
      bit      one_axis;
      longint  x, s, y, v, d;
      longint  x1, x2, y1, y2, held;
      one_axis = (cfg_shadow.axis_count == alpd_pkg::AXIS_COUNT_ONE);
      ax = one_axis ? 0 : int'(sample.axis);
      x1 = $signed(axis_hist[ax].x1);
      x2 = $signed(axis_hist[ax].x2);
      y1 = $signed(axis_hist[ax].y1);
      y2 = $signed(axis_hist[ax].y2);
      held = $signed(axis_hist[ax].held);
      x = $signed(sample.raw_sample);
      x = x <<< (one_axis ? alpd_pkg::SHIFT_ONE : alpd_pkg::SHIFT_TWO);
      v = x;
      if (cfg_shadow.filter_enable) begin
         s = x + 2 * x1 + x2;
         y = ((longint'(alpd_pkg::COEF_FB) * y1) >>> alpd_pkg::COEF_BITS)
           + ((longint'(alpd_pkg::COEF_FB2) * y2) >>> alpd_pkg::COEF_BITS)
           + ((longint'(alpd_pkg::COEF_FF) * s) >>> alpd_pkg::COEF_BITS);
         if (y > ANGLE_MAX) begin
            y = ANGLE_MAX;
         end else if (y < ANGLE_MIN) begin
            y = ANGLE_MIN;
         end
         axis_hist[ax].x2 = x1[31:0];
         axis_hist[ax].x1 = x[31:0];
         axis_hist[ax].y2 = y1[31:0];
         axis_hist[ax].y1 = y[31:0];
         v = y;
      end
      if (cfg_shadow.deadzone_enable) begin
         d = v - held;
         if (d < 0) begin
            d = -d;
         end
         if (d > longint'(cfg_shadow.hold_thresh)) begin
            axis_hist[ax].held = v[31:0];
         end else begin
            v = held;
         end
      end
      result.axis_out = ax[alpd_pkg::AXIS_W-1:0];
      result.angle = v[31:0];
      return result;
   endfunction

   always @(posedge clock) begin : track_and_check
      alpd_pkg::rsp_type want;
      if (reset) begin
         cfg_shadow.axis_count = alpd_pkg::AXIS_COUNT_RESET;
         cfg_shadow.filter_enable = 1'b1;
         cfg_shadow.deadzone_enable = 1'b1;
         cfg_shadow.hold_thresh = alpd_pkg::HOLD_THRESH_RESET;
         for (int i = 0; i < alpd_pkg::MAX_AXES; i++) begin
            axis_hist[i] = '0;
         end
      end else begin
         if (csr_we) begin
            case (alpd_pkg::csr_reg_type'(csr_index))
               alpd_pkg::REG_AXIS_COUNT:      cfg_shadow.axis_count = csr_wdata[1:0];
               alpd_pkg::REG_FILTER_ENABLE:   cfg_shadow.filter_enable = csr_wdata[0];
               alpd_pkg::REG_DEADZONE_ENABLE: cfg_shadow.deadzone_enable = csr_wdata[0];
               alpd_pkg::REG_HOLD_THRESH:
                  cfg_shadow.hold_thresh = csr_wdata[alpd_pkg::DZ_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_angles.push_back(predict_angle(req_data));
            samples_accepted++;
            req_beat_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_beat_taken = 1'b1;
            if (expected_angles.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected beat: expected none, actual axis %0d angle %0d",
                        $time, rsp_data.axis_out, $signed(rsp_data.angle));
            end else begin
               want = expected_angles.pop_front();
               if (rsp_data.axis_out !== want.axis_out) begin
                  mismatch_count++;
                  $display("%0t axis_out mismatch: expected %0d, actual %0d",
                           $time, want.axis_out, rsp_data.axis_out);
               end
               if (rsp_data.angle !== want.angle) begin
                  mismatch_count++;
                  $display("%0t angle mismatch: expected %0d, actual %0d",
                           $time, $signed(want.angle), $signed(rsp_data.angle));
               end
            end
         end
      end
   end

   always @(negedge clock) begin : drive_req
      logic valid_next;
      valid_next = req_valid;
      if (reset) begin
         valid_next = 1'b0;
      end else begin
         if (req_beat_taken) begin
            req_beat_taken = 1'b0;
            valid_next = 1'b0;
            req_gap = $urandom_range(0, req_idle_max);
         end
         if (!valid_next) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_samples.size() > 0) begin
               req_data <= pending_samples.pop_front();
               valid_next = 1'b1;
            end
         end
      end
      req_valid <= valid_next;
   end

   always @(negedge clock) begin : drive_rsp_stall
      if (rsp_beat_taken) begin
         rsp_beat_taken = 1'b0;
         rsp_wait = $urandom_range(0, rsp_idle_max);
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(alpd_pkg::csr_reg_type idx,
                            logic [alpd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Upper bits carry noise so that the register width masking is exercised.
   task automatic set_config(logic [1:0] axes, bit filt, bit dz_on,
                             logic [alpd_pkg::DZ_W-1:0] zone);
      logic [alpd_pkg::CSR_DATA_W-1:0] noise;
      noise = alpd_pkg::CSR_DATA_W'($urandom);
      write_reg(alpd_pkg::REG_AXIS_COUNT, {noise[alpd_pkg::CSR_DATA_W-1:2], axes});
      noise = alpd_pkg::CSR_DATA_W'($urandom);
      write_reg(alpd_pkg::REG_FILTER_ENABLE, {noise[alpd_pkg::CSR_DATA_W-1:1], filt});
      noise = alpd_pkg::CSR_DATA_W'($urandom);
      write_reg(alpd_pkg::REG_DEADZONE_ENABLE, {noise[alpd_pkg::CSR_DATA_W-1:1], dz_on});
      write_reg(alpd_pkg::REG_HOLD_THRESH, zone);
   endtask

   task automatic queue_sample(int axis_sel, int raw);
      alpd_pkg::req_type sample;
      sample.axis = alpd_pkg::AXIS_W'(axis_sel);
      sample.raw_sample = 16'(raw);
      pending_samples.push_back(sample);
      samples_queued++;
   endtask

   // Mostly slow random walks per axis, so the filter and deadzone see realistic motion.
   task automatic queue_random(int count);
      int pick;
      int ax;
      for (int i = 0; i < count; i++) begin
         ax = $urandom_range(0, 1);
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            walk[ax] = walk[ax] + int'($urandom_range(0, 128)) - 64;
            if (walk[ax] > 32767) begin
               walk[ax] = 32767;
            end else if (walk[ax] < -32768) begin
               walk[ax] = -32768;
            end
            queue_sample(ax, walk[ax]);
         end else if (pick < 9) begin
            queue_sample(ax, $urandom);
         end else begin
            queue_sample(ax, ($urandom_range(0, 1) != 0) ? 32767 : -32768);
         end
      end
   endtask

   task automatic wait_drained();
      while (samples_accepted != samples_queued || expected_angles.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [alpd_pkg::DZ_W-1:0] zone;
      logic [1:0]                axes;
      int                        zone_pick;
      walk[0] = 0;
      walk[1] = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      queue_sample(0, 32767);
      queue_sample(0, 32767);
      queue_sample(0, 32767);
      queue_sample(1, 16);
      queue_sample(1, 17);
      queue_sample(1, 15);
      queue_sample(0, -32768);
      queue_sample(0, -32768);
      queue_sample(1, -32768);
      queue_sample(0, 0);
      queue_sample(0, 1);
      queue_sample(0, -1);
      wait_drained();

      // One-axis mode ignores the axis bit, and a zero threshold holds on equal values.
      set_config(alpd_pkg::AXIS_COUNT_ONE, 1'b0, 1'b1, '0);
      @(posedge clock);
      queue_sample(1, 0);
      queue_sample(1, 1);
      queue_sample(1, 1);
      queue_sample(1, -1);
      queue_sample(1, 32767);
      queue_sample(1, -32768);
      wait_drained();

      set_config(2'd3, 1'b1, 1'b0, '1);
      @(posedge clock);
      queue_sample(1, -32768);
      queue_sample(1, 32767);
      queue_sample(0, 32767);
      queue_sample(0, 0);
      queue_sample(1, 0);
      wait_drained();

      for (int p = 0; p < 12; p++) begin
         zone_pick = $urandom_range(0, 3);
         case (zone_pick)
            0:       zone = '0;
            1:       zone = '1;
            2:       zone = alpd_pkg::DZ_W'($urandom_range(0, 1 << 17));
            default: zone = alpd_pkg::DZ_W'($urandom);
         endcase
         axes = (p < 4) ? p[1:0] : 2'($urandom_range(0, 3));
         set_config(axes, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, zone);
         @(posedge clock);
         req_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
         rsp_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
         if (p == 5) begin
            req_idle_max = 0;
            long_hold = 120;
         end
         queue_random(75);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/alpd_pkg.sv
rtl/core/alpd_csr.sv
rtl/core/alpd_state_mem.sv
rtl/core/alpd_pipe.sv
rtl/core/angle_lowpass_deadzone_unit.sv
verif/tb_top.sv
